### src/assert_macros.svh
// Assertion helpers shared by the bsb modules.
// All of them sample on clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every sampled edge
`define BSB_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// a implies b in the same cycle
`define BSB_IMPLY(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define BSB_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

### src/bsb_pkg.sv
package bsb_pkg;

  localparam int SLOTS     = 64;
  localparam int READERS   = 8;
  localparam int WORD_BITS = 32;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int RID_W = $clog2(READERS);
  localparam int CNT_W = $clog2(READERS + 1);
  localparam int CFG_W = 7;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_FIELDS_W  = IDX_W + WORD_BITS + RID_W;
  localparam int OUT_FIELDS_W = WORD_BITS + RID_W + CNT_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_ATTACH = 2'd2,
    KIND_DETACH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_NO_FREE   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // item accepted this cycle
    logic exec;    // item being evaluated
    logic commit;  // evaluation done, state and result written
    logic sweep;   // pending column clear in progress
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic grant;       // current item is an attach that succeeds
    logic sweep_last;  // last cycle of the column clear
  } stat_t;

endpackage

### src/broadcast_slot_buffer.sv
// Channel   Dir  Accepted when                   Carries
// s_axis    in   s_axis_tvalid & s_axis_tready   one command item
// m_axis    out  m_axis_tvalid & m_axis_tready   one result item per command
// cfg       in   cfg_valid & cfg_ready           slots_in_use (7 bits)
//
// Each item is accepted (slot memories read), then evaluated and committed;
// the registered read of the slot memories lies between those steps.
// A granted attach then goes on to clear its pending column,
// one memory row a cycle through the pending RAM port; no item is taken then.
// A result waiting in m_axis holds the next item in its evaluate cycle.
// Reset clears control state; pending rows read as zero through per-row
// valid flags, so no clearing pass follows reset. cfg is always ready.
module broadcast_slot_buffer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot_index[5:0], write_value[37:6], reader_id[40:38], zero pad
  input  logic [bsb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_value[31:0], assigned_reader[34:32], readers_attached[38:35], zero pad
  output logic [bsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsb_pkg::CFG_W-1:0]        cfg_data
);

  localparam int IDX_W = bsb_pkg::IDX_W;
  localparam int RID_W = bsb_pkg::RID_W;
  localparam int WB    = bsb_pkg::WORD_BITS;
  localparam int CNT_W = bsb_pkg::CNT_W;

  bsb_pkg::cmd_t  cmd;
  bsb_pkg::stat_t stat;

  logic [IDX_W-1:0]     in_idx;
  logic signed [WB-1:0] in_wval;
  logic [RID_W-1:0]     in_rid;

  logic signed [WB-1:0] out_rval;
  logic [RID_W-1:0]     out_granted;
  logic [CNT_W-1:0]     out_count;

  // unpack the command item
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_wval = s_axis_tdata[IDX_W +: WB];
  assign in_rid  = s_axis_tdata[IDX_W + WB +: RID_W];

  assign cfg_ready = 1'b1;

  bsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (s_axis_tuser),
    .in_idx      (in_idx),
    .in_wval     (in_wval),
    .in_rid      (in_rid),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_status  (m_axis_tuser),
    .out_rval    (out_rval),
    .out_granted (out_granted),
    .out_count   (out_count)
  );

  // pack the result item, pad bits zero
  assign m_axis_tdata = bsb_pkg::OUT_DATA_W'({out_count, out_granted, out_rval});

endmodule

### src/bsb_ram.sv
module bsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bsb_ctrl.sv
`include "assert_macros.svh"

module bsb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bsb_pkg::stat_t stat,
  output bsb_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = stat.grant ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BSB_NEXT(a_accept_to_exec, in_valid && in_ready, state == S_EXEC, "accepted item not evaluated")
  `BSB_NEXT(a_grant_sweeps, cmd.commit && stat.grant, state == S_CLEAR, "attach without clear")
  `BSB_NEXT(a_sweep_ends, cmd.sweep && stat.sweep_last, state == S_IDLE, "clear did not end")

endmodule

### src/bsb_dp.sv
`include "assert_macros.svh"

module bsb_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bsb_pkg::cmd_t                       cmd,
  output bsb_pkg::stat_t                      stat,
  input  logic [1:0]                          in_kind,
  input  logic [bsb_pkg::IDX_W-1:0]           in_idx,
  input  logic signed [bsb_pkg::WORD_BITS-1:0] in_wval,
  input  logic [bsb_pkg::RID_W-1:0]           in_rid,
  input  logic                                cfg_we,
  input  logic [bsb_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [bsb_pkg::WORD_BITS-1:0] out_rval,
  output logic [bsb_pkg::RID_W-1:0]           out_granted,
  output logic [bsb_pkg::CNT_W-1:0]           out_count
);

  localparam int IDX_W = bsb_pkg::IDX_W;
  localparam int RID_W = bsb_pkg::RID_W;
  localparam int RDR   = bsb_pkg::READERS;
  localparam int WB    = bsb_pkg::WORD_BITS;

  // item registers
  bsb_pkg::kind_t          kind_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [WB-1:0]    wval_q;
  logic [RID_W-1:0]        rid_q;

  // block state
  logic [bsb_pkg::CFG_W-1:0] slots_in_use;
  logic [RDR-1:0]            attached, attached_next;
  logic [bsb_pkg::CNT_W-1:0] count, count_next;
  logic [bsb_pkg::SLOTS-1:0] row_valid;
  logic                      rvalid_q;

  // column clear
  logic [IDX_W:0]   sw_cnt;
  logic [RID_W-1:0] sweep_rid;

  // memory ports
  logic [IDX_W-1:0] raddr;
  logic [WB-1:0]    data_rd;
  logic [RDR-1:0]   pend_rd, pend_eff;
  logic             data_we, pend_we;
  logic [IDX_W-1:0] pend_waddr;
  logic [RDR-1:0]   pend_wdata;

  // evaluation
  bsb_pkg::status_t  st_c;
  logic [WB-1:0]     rval_c;
  logic [RID_W-1:0]  free_id;
  logic              found, grant_ok, in_range;
  logic              data_we_c, pend_we_c;
  logic [RDR-1:0]    pend_new_c;

  assign raddr = cmd.sweep ? sw_cnt[IDX_W-1:0] : (cmd.exec ? idx_q : in_idx);
  assign pend_eff = rvalid_q ? pend_rd : '0;
  assign in_range = {1'b0, idx_q} < slots_in_use;

  always_comb begin
    found   = 1'b0;
    free_id = '0;
    for (int i = RDR - 1; i >= 0; i--) begin
      if (!attached[i]) begin
        found   = 1'b1;
        free_id = RID_W'(i);
      end
    end
  end

  always_comb begin
    st_c          = bsb_pkg::STAT_OK;
    rval_c        = '0;
    grant_ok      = 1'b0;
    data_we_c     = 1'b0;
    pend_we_c     = 1'b0;
    pend_new_c    = pend_eff;
    attached_next = attached;
    count_next    = count;
    unique case (kind_q)
      bsb_pkg::KIND_WRITE: begin
        if (!in_range) begin
          st_c = bsb_pkg::STAT_BAD_INDEX;
        end else if ((pend_eff & attached) != '0) begin
          st_c = bsb_pkg::STAT_NOT_READY;
        end else begin
          data_we_c  = 1'b1;
          pend_we_c  = 1'b1;
          pend_new_c = pend_eff | attached;
        end
      end
      bsb_pkg::KIND_READ: begin
        if (!attached[rid_q]) begin
          st_c = bsb_pkg::STAT_NOT_READY;
        end else if (!in_range) begin
          st_c = bsb_pkg::STAT_BAD_INDEX;
        end else if (!pend_eff[rid_q]) begin
          st_c = bsb_pkg::STAT_NOT_READY;
        end else begin
          rval_c            = data_rd;
          pend_we_c         = 1'b1;
          pend_new_c[rid_q] = 1'b0;
        end
      end
      bsb_pkg::KIND_ATTACH: begin
        if (count >= bsb_pkg::CNT_W'(RDR) || !found) begin
          st_c = bsb_pkg::STAT_NO_FREE;
        end else begin
          grant_ok               = 1'b1;
          attached_next[free_id] = 1'b1;
          count_next             = count + 1'b1;
        end
      end
      bsb_pkg::KIND_DETACH: begin
        if (attached[rid_q]) begin
          attached_next[rid_q] = 1'b0;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        st_c = bsb_pkg::STAT_OK;
      end
    endcase
  end

  // sweep writes row sw_cnt-1 while reading row sw_cnt
  always_comb begin
    data_we    = cmd.commit && data_we_c;
    pend_we    = 1'b0;
    pend_waddr = idx_q;
    pend_wdata = pend_new_c;
    if (cmd.sweep) begin
      pend_we    = sw_cnt != '0;
      pend_waddr = IDX_W'(sw_cnt - 1'b1);
      pend_wdata = pend_eff;
      pend_wdata[sweep_rid] = 1'b0;
    end else if (cmd.commit) begin
      pend_we = pend_we_c;
    end
  end

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.grant      = grant_ok;
  assign stat.sweep_last = sw_cnt == (IDX_W + 1)'(bsb_pkg::SLOTS);

  bsb_ram #(.WIDTH(WB), .DEPTH(bsb_pkg::SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (idx_q),
    .wdata (wval_q),
    .raddr (raddr),
    .rdata (data_rd)
  );

  bsb_ram #(.WIDTH(RDR), .DEPTH(bsb_pkg::SLOTS)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (raddr),
    .rdata (pend_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= bsb_pkg::CFG_W'(bsb_pkg::SLOTS);
      attached     <= '0;
      count        <= '0;
      row_valid    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_data;
      end
      if (cmd.commit) begin
        attached  <= attached_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pend_we) begin
        row_valid[pend_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rvalid_q <= row_valid[raddr];
    if (cmd.load) begin
      kind_q <= bsb_pkg::kind_t'(in_kind);
      idx_q  <= in_idx;
      wval_q <= in_wval;
      rid_q  <= in_rid;
    end
    if (cmd.commit) begin
      out_status  <= st_c;
      out_rval    <= rval_c;
      out_granted <= grant_ok ? free_id : '0;
      out_count   <= count_next;
    end
    if (cmd.commit && grant_ok) begin
      sw_cnt    <= '0;
      sweep_rid <= free_id;
    end else if (cmd.sweep) begin
      sw_cnt <= sw_cnt + 1'b1;
    end
  end

  `BSB_HOLDS(a_count_matches, count == bsb_pkg::CNT_W'($countones(attached)), "count drift")
  `BSB_IMPLY(a_no_overwrite, cmd.commit, !out_valid || out_ready, "result overwritten")
  `BSB_NEXT(a_commit_shows, cmd.commit, out_valid, "result lost")

endmodule
